// ===== design/swba_pkg.sv =====
// ----------------------------------------------------------------------------
// swba_pkg
// Shared types, register indexes and reset values for the scaled window blit
// addresser.
// ----------------------------------------------------------------------------
package swba_pkg;

    localparam int DEFAULT_MAX_SCREEN_DIM = 4096;

    localparam int COORD_W    = 12;
    localparam int INDEX_W    = 24;
    localparam int DIM_CFG_W  = 13;
    localparam int SCALE_W    = 17;
    localparam int INV_W      = 20;
    localparam int FRAC_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_SCREEN_WIDTH  = 3'd0;
    localparam t_cfg_addr CFG_SCREEN_HEIGHT = 3'd1;
    localparam t_cfg_addr CFG_SCALE         = 3'd2;
    localparam t_cfg_addr CFG_INV_SCALE     = 3'd3;
    localparam t_cfg_addr CFG_ANCHOR_X      = 3'd4;
    localparam t_cfg_addr CFG_ANCHOR_Y      = 3'd5;

    localparam logic [DIM_CFG_W-1:0] RST_SCREEN_WIDTH  = DIM_CFG_W'(1080);
    localparam logic [DIM_CFG_W-1:0] RST_SCREEN_HEIGHT = DIM_CFG_W'(1920);
    localparam logic [SCALE_W-1:0]   RST_SCALE         = SCALE_W'(65536);
    localparam logic [INV_W-1:0]     RST_INV_SCALE     = INV_W'(65536);
    localparam logic [COORD_W-1:0]   RST_ANCHOR        = '0;

endpackage

// ===== design/scaled_window_blit_addresser.sv =====
// ----------------------------------------------------------------------------
// scaled_window_blit_addresser
// Destination and source pixel addresses for a nearest-neighbor scaled window
// copy, one coordinate per clock through a five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  command   | i_start, o_busy         | i_window_x, i_window_y
//  result    | o_valid (one-cycle)     | o_write_pixel, o_dest_index, o_src_index
//  config    | i_cfg_we, i_cfg_addr    | i_cfg_wdata
//
//  One transaction per clock; o_busy is always low.
//  Results appear in command order.
//  The pipeline stages are the input capture, the scale multipliers, the anchor
//  clamp, the bounds compare and the row-times-pitch multiply, one stage each.
//  Synchronous active-low reset loads the config reset values and clears the
//  valid bits.
//  The receiver cannot stall; results leave on o_valid.
// ----------------------------------------------------------------------------
module scaled_window_blit_addresser
    import swba_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = DEFAULT_MAX_SCREEN_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [COORD_W-1:0]    i_window_x,
    input  logic [COORD_W-1:0]    i_window_y,
    output logic                  o_valid,
    output logic                  o_write_pixel,
    output logic [INDEX_W-1:0]    o_dest_index,
    output logic [INDEX_W-1:0]    o_src_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int DW   = $clog2(MAX_SCREEN_DIM + 1);
    localparam int CMPW = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
    localparam int SW   = (DW > FRAC_W) ? DW : FRAC_W;
    localparam int AW   = ((DW > COORD_W) ? DW : COORD_W) + 2;
    localparam int PW   = ((2 * DW + 1) > INDEX_W) ? (2 * DW + 1) : INDEX_W;
    localparam int MW   = DW + SCALE_W;
    localparam int XW   = COORD_W + INV_W;

    // configuration
    logic [DIM_CFG_W-1:0] r_screen_width, r_screen_height;
    logic [SCALE_W-1:0]   r_scale;
    logic [INV_W-1:0]     r_inv_scale;
    logic [COORD_W-1:0]   r_anchor_x, r_anchor_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_scale         <= RST_SCALE;
            r_inv_scale     <= RST_INV_SCALE;
            r_anchor_x      <= RST_ANCHOR;
            r_anchor_y      <= RST_ANCHOR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata[DIM_CFG_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata[DIM_CFG_W-1:0];
                CFG_SCALE:         r_scale         <= i_cfg_wdata[SCALE_W-1:0];
                CFG_INV_SCALE:     r_inv_scale     <= i_cfg_wdata[INV_W-1:0];
                CFG_ANCHOR_X:      r_anchor_x      <= i_cfg_wdata[COORD_W-1:0];
                CFG_ANCHOR_Y:      r_anchor_y      <= i_cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated screen size and scale
    logic [DW-1:0]      w_sat, h_sat;
    logic [SCALE_W-1:0] sc_sat;

    always_comb begin
        w_sat  = (CMPW'(r_screen_width) > CMPW'(MAX_SCREEN_DIM)) ?
                 DW'(MAX_SCREEN_DIM) : DW'(r_screen_width);
        h_sat  = (CMPW'(r_screen_height) > CMPW'(MAX_SCREEN_DIM)) ?
                 DW'(MAX_SCREEN_DIM) : DW'(r_screen_height);
        sc_sat = (r_scale > SCALE_ONE) ? SCALE_ONE : r_scale;
    end

    assign o_busy = 1'b0;

    // stage 1: capture coordinates
    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_wx, r_s1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_wx <= i_window_x;
        r_s1_wy <= i_window_y;
    end

    // stage 2: scaled size and source coordinates
    logic [MW-1:0]      n_prod_w, n_prod_h;
    logic [XW-1:0]      n_prod_sx, n_prod_sy;
    logic               r_s2_valid;
    logic [COORD_W-1:0] r_s2_wx, r_s2_wy;
    logic [DW-1:0]      r_s2_scaled_w, r_s2_scaled_h;
    logic [FRAC_W-1:0]  r_s2_sx, r_s2_sy;

    always_comb begin
        n_prod_w  = MW'(w_sat) * MW'(sc_sat);
        n_prod_h  = MW'(h_sat) * MW'(sc_sat);
        n_prod_sx = XW'(r_s1_wx) * XW'(r_inv_scale);
        n_prod_sy = XW'(r_s1_wy) * XW'(r_inv_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_wx       <= r_s1_wx;
        r_s2_wy       <= r_s1_wy;
        r_s2_scaled_w <= n_prod_w[FRAC_W +: DW];
        r_s2_scaled_h <= n_prod_h[FRAC_W +: DW];
        r_s2_sx       <= n_prod_sx[FRAC_W +: FRAC_W];
        r_s2_sy       <= n_prod_sy[FRAC_W +: FRAC_W];
    end

    // stage 3: clamp anchor, offset of the window's top-left corner
    logic [AW-1:0]      n_hw, n_sh, n_cx1, n_cx2, n_by1, n_by2;
    logic               r_s3_valid;
    logic [COORD_W-1:0] r_s3_wx, r_s3_wy;
    logic [DW-1:0]      r_s3_scaled_w, r_s3_scaled_h;
    logic [FRAC_W-1:0]  r_s3_sx, r_s3_sy;
    logic [AW-1:0]      r_s3_x_off, r_s3_y_off;

    always_comb begin
        n_hw  = AW'(r_s2_scaled_w >> 1);
        n_sh  = AW'(r_s2_scaled_h);
        n_cx1 = (AW'(r_anchor_x) < n_hw) ? n_hw : AW'(r_anchor_x);
        n_cx2 = ((n_cx1 + n_hw) > AW'(w_sat)) ? (AW'(w_sat) - n_hw) : n_cx1;
        n_by1 = (AW'(r_anchor_y) < n_sh) ? n_sh : AW'(r_anchor_y);
        n_by2 = (n_by1 > AW'(h_sat)) ? AW'(h_sat) : n_by1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_wx       <= r_s2_wx;
        r_s3_wy       <= r_s2_wy;
        r_s3_scaled_w <= r_s2_scaled_w;
        r_s3_scaled_h <= r_s2_scaled_h;
        r_s3_sx       <= r_s2_sx;
        r_s3_sy       <= r_s2_sy;
        r_s3_x_off    <= n_cx2 - n_hw;
        r_s3_y_off    <= n_by2 - n_sh;
    end

    // stage 4: destination coordinates and bounds
    logic [AW-1:0] n_dx, n_dy;
    logic          n_ok;
    logic          r_s4_valid, r_s4_ok;
    logic [DW-1:0] r_s4_dx, r_s4_dy, r_s4_sx, r_s4_sy;

    always_comb begin
        n_dx = r_s3_x_off + AW'(r_s3_wx);
        n_dy = r_s3_y_off + AW'(r_s3_wy);
        n_ok = (AW'(r_s3_wx) < AW'(r_s3_scaled_w)) &&
               (AW'(r_s3_wy) < AW'(r_s3_scaled_h)) &&
               (n_dx < AW'(w_sat)) && (n_dy < AW'(h_sat)) &&
               (SW'(r_s3_sx) < SW'(w_sat)) && (SW'(r_s3_sy) < SW'(h_sat));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_ok <= n_ok;
        r_s4_dx <= n_dx[DW-1:0];
        r_s4_dy <= n_dy[DW-1:0];
        r_s4_sx <= SW'(r_s3_sx) < SW'(w_sat) ? DW'(r_s3_sx) : '0;
        r_s4_sy <= SW'(r_s3_sy) < SW'(h_sat) ? DW'(r_s3_sy) : '0;
    end

    // stage 5: linear indexes
    logic [PW-1:0]      n_dest, n_src;
    logic               r_out_valid, r_out_write;
    logic [INDEX_W-1:0] r_out_dest, r_out_src;

    always_comb begin
        n_dest = PW'(r_s4_dy) * PW'(w_sat) + PW'(r_s4_dx);
        n_src  = PW'(r_s4_sy) * PW'(w_sat) + PW'(r_s4_sx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_write <= 1'b0;
        end else begin
            r_out_valid <= r_s4_valid;
            r_out_write <= r_s4_valid && r_s4_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dest <= r_s4_ok ? n_dest[INDEX_W-1:0] : '0;
        r_out_src  <= r_s4_ok ? n_src[INDEX_W-1:0] : '0;
    end

    assign o_valid       = r_out_valid;
    assign o_write_pixel = r_out_write;
    assign o_dest_index  = r_out_dest;
    assign o_src_index   = r_out_src;

`ifndef SYNTHESIS
    a_write_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_pixel |-> o_valid)
        else $error("write flag without result strobe");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##5 o_valid)
        else $error("accepted transaction produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 5))
        else $error("result without an accepted transaction");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_pixel) |-> (o_dest_index == '0 && o_src_index == '0))
        else $error("skipped pixel with nonzero indexes");

    a_dest_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && r_s4_ok) |-> (r_s4_dx < w_sat && r_s4_dy < h_sat))
        else $error("destination outside screen marked writable");
`endif

endmodule
